[sv/utis_pkg.sv]
package utis_pkg;

  // Store geometry; CAPACITY must be a multiple of GRP_N
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int GRP_N    = 8;
  localparam int GRP_W    = $clog2(GRP_N);
  localparam int NGRP     = CAPACITY / GRP_N;
  localparam int TAG_W    = 32;

  // Register map
  localparam logic [1:0] ADDR_KEEP_SORTED = 2'd0;

  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_LOOKUP  = 3'd1,
    CMD_REM_VAL = 3'd2,
    CMD_REM_POS = 3'd3,
    CMD_READ    = 3'd4,
    CMD_FLUSH   = 3'd5
  } utis_cmd_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_PRESENT   = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_ZERO      = 3'd3,
    STS_FULL      = 3'd4,
    STS_RANGE     = 3'd5
  } utis_status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE
  } utis_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_GRP,
    ST_EXEC
  } utis_state_e;

  typedef struct packed {
    logic [2:0]        command;
    logic signed [31:0] tag_value;
    logic [5:0]        position;
  } utis_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [5:0]        where_found;
    logic signed [31:0] read_value;
    logic [6:0]        tag_count;
  } utis_out_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    utis_op_e          op;
    logic [IDX_W-1:0]  at;
    logic              cap;
    logic [TAG_W-1:0]  tag;
    logic [5:0]        pos;
    logic [CNT_W-1:0]  count;
  } utis_ctrl_t;

  typedef struct packed {
    logic eq;
    logic gt;
    logic sel;
  } utis_flags_t;

  typedef struct packed {
    logic              any_eq;
    logic [GRP_W-1:0]  eq_idx;
    logic              any_gt;
    logic [GRP_W-1:0]  gt_idx;
    logic [TAG_W-1:0]  rd;
  } utis_grp_t;

endpackage

[sv/utis_cell.sv]
module utis_cell (
  input  logic                          clk_i,
  input  logic [utis_pkg::IDX_W-1:0]    idx_i,
  input  utis_pkg::utis_ctrl_t          ctrl_i,
  input  logic [utis_pkg::TAG_W-1:0]    left_i,
  input  logic [utis_pkg::TAG_W-1:0]    right_i,
  output logic [utis_pkg::TAG_W-1:0]    value_o,
  output utis_pkg::utis_flags_t         flags_o
);
  import utis_pkg::*;

  logic [TAG_W-1:0] val_q, val_d;
  utis_flags_t      flags_q, flags_d;
  logic             valid;

  // entry holds a live tag
  assign valid = {1'b0, idx_i} < ctrl_i.count;

  // compare against the broadcast tag and position
  always_comb begin
    flags_d.eq  = valid && (val_q == ctrl_i.tag);
    flags_d.gt  = valid && ($signed(val_q) > $signed(ctrl_i.tag));
    flags_d.sel = valid && (CNT_W'(ctrl_i.pos) == CNT_W'(idx_i));
  end

  // shift up on insert, shift down on delete
  always_comb begin
    val_d = val_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (idx_i > ctrl_i.at) val_d = left_i;
        else if (idx_i == ctrl_i.at) val_d = ctrl_i.tag;
      end
      OP_DELETE: begin
        if (idx_i >= ctrl_i.at) val_d = right_i;
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (ctrl_i.cap) flags_q <= flags_d;
  end

  assign value_o = val_q;
  assign flags_o = flags_q;

endmodule

[sv/utis_group.sv]
module utis_group (
  input  logic                                             clk_i,
  input  logic                                             cap_i,
  input  utis_pkg::utis_flags_t [utis_pkg::GRP_N-1:0]      flags_i,
  input  logic [utis_pkg::GRP_N-1:0][utis_pkg::TAG_W-1:0]  value_i,
  output utis_pkg::utis_grp_t                              grp_o
);
  import utis_pkg::*;

  utis_grp_t grp_q, grp_d;

  // first match, first greater entry and selected word within the group
  always_comb begin
    grp_d = '0;
    for (int k = GRP_N - 1; k >= 0; k--) begin
      if (flags_i[k].eq) begin
        grp_d.any_eq = 1'b1;
        grp_d.eq_idx = GRP_W'(k);
      end
      if (flags_i[k].gt) begin
        grp_d.any_gt = 1'b1;
        grp_d.gt_idx = GRP_W'(k);
      end
      if (flags_i[k].sel) grp_d.rd = grp_d.rd | value_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_i) grp_q <= grp_d;
  end

  assign grp_o = grp_q;

endmodule

[sv/unique_int_tag_set.sv]
// An accepted word passes through the compare, group-search and commit steps
// over the cell chain, which work on one command at a time; the input stalls
// until the command commits and its result word is registered on the output.
// A held result does not block the next command until that one commits.
// Reset clears the tag count, keep_sorted, the sequencer and the output valid flag;
// the tag cells themselves are not cleared.
module unique_int_tag_set (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  utis_pkg::utis_in_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output utis_pkg::utis_out_t  out_word_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import utis_pkg::*;

  utis_state_e state_q, state_d;
  utis_in_t    item_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic        keep_sorted_q;
  logic        out_valid_q;
  utis_out_t   out_word_q, out_word_d;
  logic        accept, fire;

  utis_ctrl_t  ctrl;
  utis_op_e    op_sel;
  logic [IDX_W-1:0] at_sel;

  utis_flags_t [CAPACITY-1:0]         flags;
  logic [CAPACITY-1:0][TAG_W-1:0]     values;
  utis_grp_t [NGRP-1:0]               grp;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_KEEP_SORTED) ? {31'd0, keep_sorted_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_sorted_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_KEEP_SORTED) begin
      keep_sorted_q <= pwdata[0];
    end
  end

  // sequencer
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_CMP;
      ST_CMP:  state_d = ST_GRP;
      ST_GRP:  state_d = ST_EXEC;
      ST_EXEC: if (fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_word_i;
    if (fire) out_word_q <= out_word_d;
  end

  // cell chain
  always_comb begin
    ctrl.op    = fire ? op_sel : OP_HOLD;
    ctrl.at    = at_sel;
    ctrl.cap   = (state_q == ST_CMP);
    ctrl.tag   = item_q.tag_value;
    ctrl.pos   = item_q.position;
    ctrl.count = count_q;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [TAG_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = values[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = values[i+1];
    end
    utis_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .value_o (values[i]),
      .flags_o (flags[i])
    );
  end

  // group search, registered
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    utis_group u_group (
      .clk_i   (clk_i),
      .cap_i   (state_q == ST_GRP),
      .flags_i (flags[g*GRP_N +: GRP_N]),
      .value_i (values[g*GRP_N +: GRP_N]),
      .grp_o   (grp[g])
    );
  end

  // final combine and command decode
  always_comb begin
    logic             found, any_gt;
    logic [IDX_W-1:0] fidx, gidx;
    logic [TAG_W-1:0] rd;
    logic             pos_ok;

    found  = 1'b0;
    any_gt = 1'b0;
    fidx   = '0;
    gidx   = '0;
    rd     = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp[g].any_eq) begin
        found = 1'b1;
        fidx  = IDX_W'(g * GRP_N) | IDX_W'(grp[g].eq_idx);
      end
      if (grp[g].any_gt) begin
        any_gt = 1'b1;
        gidx   = IDX_W'(g * GRP_N) | IDX_W'(grp[g].gt_idx);
      end
      rd = rd | grp[g].rd;
    end
    pos_ok = CNT_W'(item_q.position) < count_q;

    op_sel     = OP_HOLD;
    at_sel     = '0;
    count_d    = count_q;
    out_word_d = '0;

    unique case (item_q.command)
      CMD_INSERT: begin
        if (item_q.tag_value == '0) begin
          out_word_d.status = STS_ZERO;
        end else if (found) begin
          out_word_d.status      = STS_PRESENT;
          out_word_d.where_found = 6'(fidx);
        end else if (count_q == CNT_W'(CAPACITY)) begin
          out_word_d.status = STS_FULL;
        end else begin
          op_sel  = OP_INSERT;
          at_sel  = (keep_sorted_q && any_gt) ? gidx : IDX_W'(count_q);
          count_d = count_q + CNT_W'(1);
          out_word_d.where_found = 6'(at_sel);
        end
      end
      CMD_LOOKUP: begin
        if (found) out_word_d.where_found = 6'(fidx);
        else out_word_d.status = STS_NOT_FOUND;
      end
      CMD_REM_VAL: begin
        if (found) begin
          op_sel  = OP_DELETE;
          at_sel  = fidx;
          count_d = count_q - CNT_W'(1);
          out_word_d.where_found = 6'(fidx);
        end else begin
          out_word_d.status = STS_NOT_FOUND;
        end
      end
      CMD_REM_POS: begin
        if (pos_ok) begin
          op_sel  = OP_DELETE;
          at_sel  = IDX_W'(item_q.position);
          count_d = count_q - CNT_W'(1);
          out_word_d.where_found = item_q.position;
        end else begin
          out_word_d.status = STS_RANGE;
        end
      end
      CMD_READ: begin
        if (pos_ok) out_word_d.read_value = rd;
        else out_word_d.status = STS_RANGE;
      end
      CMD_FLUSH: count_d = '0;
      default: ;
    endcase
    out_word_d.tag_count = 7'(count_d);
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[sv/utis_checker.sv]
module utis_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  utis_pkg::utis_out_t  out_word_o
);
  import utis_pkg::*;

  // one command in flight: stall rises right after an accepted word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // count never exceeds capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.tag_count <= 7'(CAPACITY))
    else $error("tag count beyond capacity");

  // full status only with a full store
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == STS_FULL |->
      out_word_o.tag_count == 7'(CAPACITY))
    else $error("full status with free entries");

  // an existing tag sits below the count
  a_present_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == STS_PRESENT |->
      {1'b0, out_word_o.where_found} < out_word_o.tag_count)
    else $error("present position beyond count");

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result changed");

endmodule

bind unique_int_tag_set utis_checker u_utis_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
